// File: rtl/core/top_k_peak_and_quantile_defines.svh
// Assertion macros shared by the top-k selection RTL.
`ifndef TOP_K_PEAK_AND_QUANTILE_DEFINES_SVH
`define TOP_K_PEAK_AND_QUANTILE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TKPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define TKPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tkpq_pkg.sv
// Package: constants, register map, state and control types of the top-k selector.
package tkpq_pkg;

  localparam int CAPACITY_DEF      = 64;
  localparam int VALUE_WIDTH_DEF   = 48;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int ID_WIDTH     = 31;
  localparam int OUT_ID_WIDTH = 32;
  localparam int MODE_WIDTH   = 1;
  localparam int KEEP_WIDTH   = 7;
  localparam int QRANK_WIDTH  = 6;

  localparam int ADDR_WIDTH  = 4;
  localparam int APB_DWIDTH  = 32;

  // padding magnitude before scaling to fixed point
  localparam logic [63:0] PAD_MAGNITUDE = 64'd10000000;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_KEEP  = 2'd1;
  localparam logic [1:0] REG_QRANK = 2'd2;

  localparam logic MODE_MIN = 1'b0;
  localparam logic MODE_MAX = 1'b1;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_PEAK,
    ST_DRAIN
  } tkpq_state_e;

  // broadcast control to every cell of the chain
  typedef struct packed {
    logic ins;    // insert the incoming record
    logic mode;   // 1: larger keys rank first
    logic shift;  // move every record one cell toward the head
    logic clear;  // empty the whole chain
  } tkpq_ctl_t;

endpackage

// File: rtl/core/top_k_peak_and_quantile.sv
// Top level: streaming top-k selector with peak and quantile report.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: sort_key, element_id, companion value;
//                                           tlast: last_record
//  m_axis    out  m_axis_tvalid/tready      tdata: peak_key, peak_id, peak_second,
//                                           quant_key, quant_id, quant_second
//  apb       in   psel/penable/pready       search_mode, keep_count, quantile_rank
//
// A record is taken every cycle in the run state; all cells compare with it at once and shift in parallel.
// After a last record: rank 0 is latched as the peak once no pending result is left to go,
// then the chain shifts toward the head until rank quantile_rank sits at the head.
// No input is taken until a batch end is done; the chain empties at its end.
// The output register holds a result while new records stream in. No clearing pass at reset.
`include "top_k_peak_and_quantile_defines.svh"

module top_k_peak_and_quantile #(
  parameter int CAPACITY      = tkpq_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH   = tkpq_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = tkpq_pkg::FRACTION_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // sort_key, element_id, companion value (lowest bits first), zero fill
  input  logic [((2*VALUE_WIDTH+31+7)/8)*8-1:0] s_axis_tdata,
  // last_record
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // peak_key, peak_id, peak_second, quant_key, quant_id, quant_second
  // (lowest bits first), zero fill
  output logic [((4*VALUE_WIDTH+64+7)/8)*8-1:0] m_axis_tdata,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tkpq_pkg::ADDR_WIDTH-1:0]       paddr,
  input  logic [tkpq_pkg::APB_DWIDTH-1:0]       pwdata,
  output logic [tkpq_pkg::APB_DWIDTH-1:0]       prdata,
  output logic                                  pready
);
  import tkpq_pkg::*;

  localparam int VW   = VALUE_WIDTH;
  localparam int ODW  = ((4*VW+64+7)/8)*8;
  localparam int CW   = $clog2(CAPACITY+1);
  localparam int KW   = (CW > KEEP_WIDTH) ? CW : KEEP_WIDTH;

  localparam logic [63:0] MAG64  = PAD_MAGNITUDE << FRACTION_BITS;
  localparam logic [63:0] SIGN64 = 64'd1 << (VW-1);
  localparam logic [63:0] SMAX64 = SIGN64 - 64'd1;
  localparam logic [63:0] NEG64  = (MAG64 >= SIGN64) ? SIGN64 : (64'd0 - MAG64);
  localparam logic [VW-1:0] PAD_POS = (MAG64 > SMAX64) ? SMAX64[VW-1:0] : MAG64[VW-1:0];
  localparam logic [VW-1:0] PAD_NEG = NEG64[VW-1:0];
  localparam logic [OUT_ID_WIDTH-1:0] PAD_ID = '1;

  // ---------------- configuration registers ----------------
  logic                   mode_q, mode_d;
  logic [KEEP_WIDTH-1:0]  keep_q, keep_d;
  logic [QRANK_WIDTH-1:0] qrank_q, qrank_d;
  logic                   cfg_wr;
  logic [1:0]             reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    mode_d  = mode_q;
    keep_d  = keep_q;
    qrank_d = qrank_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODE:  mode_d  = pwdata[0];
        REG_KEEP:  keep_d  = pwdata[KEEP_WIDTH-1:0];
        REG_QRANK: qrank_d = pwdata[QRANK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:  prdata = APB_DWIDTH'(mode_q);
      REG_KEEP:  prdata = APB_DWIDTH'(keep_q);
      REG_QRANK: prdata = APB_DWIDTH'(qrank_q);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_MAX;
      keep_q  <= KEEP_WIDTH'(1);
      qrank_q <= '0;
    end else begin
      mode_q  <= mode_d;
      keep_q  <= keep_d;
      qrank_q <= qrank_d;
    end
  end

  // effective keep count, clamped to 1..CAPACITY
  logic [KW-1:0] keep_ext, keep_eff;
  assign keep_ext = KW'(keep_q);
  always_comb begin
    priority if (keep_ext == '0) begin
      keep_eff = KW'(1);
    end else if (keep_ext > KW'(CAPACITY)) begin
      keep_eff = KW'(CAPACITY);
    end else begin
      keep_eff = keep_ext;
    end
  end

  // ---------------- control ----------------
  tkpq_state_e            state_q, state_d;
  logic [QRANK_WIDTH-1:0] cnt_q, cnt_d;
  logic                   in_xfer, out_xfer;
  logic                   peak_cap, quant_cap;
  tkpq_ctl_t              ctl;
  logic                   m_valid_q, m_valid_d;

  assign in_xfer  = s_axis_tvalid & s_axis_tready;
  assign out_xfer = m_valid_q & m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN:   if (in_xfer && s_axis_tlast) state_d = ST_PEAK;
      ST_PEAK:  if (!m_valid_q) state_d = ST_DRAIN;
      ST_DRAIN: if (cnt_q == '0) state_d = ST_RUN;
      default:  state_d = ST_RUN;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    peak_cap      = 1'b0;
    quant_cap     = 1'b0;
    ctl.ins       = 1'b0;
    ctl.mode      = mode_q;
    ctl.shift     = 1'b0;
    ctl.clear     = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        s_axis_tready = 1'b1;
        ctl.ins       = s_axis_tvalid;
      end
      ST_PEAK: begin
        peak_cap = ~m_valid_q;
      end
      ST_DRAIN: begin
        quant_cap = (cnt_q == '0);
        ctl.clear = (cnt_q == '0);
        ctl.shift = (cnt_q != '0);
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer && s_axis_tlast) begin
      cnt_d = qrank_q;
    end else if (ctl.shift) begin
      cnt_d = cnt_q - QRANK_WIDTH'(1);
    end
  end

  assign m_valid_d = quant_cap ? 1'b1 : (out_xfer ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_RUN;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  // ---------------- insertion chain ----------------
  logic [VW-1:0]       new_key, new_sec;
  logic [ID_WIDTH-1:0] new_id;

  assign new_key = s_axis_tdata[VW-1:0];
  assign new_id  = s_axis_tdata[VW+ID_WIDTH-1:VW];
  assign new_sec = s_axis_tdata[2*VW+ID_WIDTH-1:VW+ID_WIDTH];

  logic [VW-1:0]       key_a [CAPACITY];
  logic [ID_WIDTH-1:0] id_a  [CAPACITY];
  logic [VW-1:0]       sec_a [CAPACITY];
  logic [CAPACITY-1:0] occ_v;
  logic [CAPACITY-1:0] go_v;
  logic [CAPACITY-1:0] above_v;
  logic [CAPACITY-1:0] range_v;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VW-1:0]       p_key, n_key, p_sec, n_sec;
    logic [ID_WIDTH-1:0] p_id, n_id;
    logic                p_occ, n_occ;

    assign range_v[i] = (keep_eff > KW'(i));

    if (i == 0) begin : g_head
      assign above_v[i] = 1'b1;
      assign p_key = '0;
      assign p_id  = '0;
      assign p_sec = '0;
      assign p_occ = 1'b0;
    end else begin : g_body
      // all cells ahead keep their records
      assign above_v[i] = &go_v[i-1:0];
      assign p_key = key_a[i-1];
      assign p_id  = id_a[i-1];
      assign p_sec = sec_a[i-1];
      assign p_occ = occ_v[i-1];
    end

    if (i == CAPACITY-1) begin : g_tail
      assign n_key = '0;
      assign n_id  = '0;
      assign n_sec = '0;
      assign n_occ = 1'b0;
    end else begin : g_mid
      assign n_key = key_a[i+1];
      assign n_id  = id_a[i+1];
      assign n_sec = sec_a[i+1];
      assign n_occ = occ_v[i+1];
    end

    tkpq_cell #(
      .VW(VW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .in_range_i   (range_v[i]),
      .above_pass_i (above_v[i]),
      .new_key_i    (new_key),
      .new_id_i     (new_id),
      .new_sec_i    (new_sec),
      .prev_key_i   (p_key),
      .prev_id_i    (p_id),
      .prev_sec_i   (p_sec),
      .prev_occ_i   (p_occ),
      .next_key_i   (n_key),
      .next_id_i    (n_id),
      .next_sec_i   (n_sec),
      .next_occ_i   (n_occ),
      .key_o        (key_a[i]),
      .id_o         (id_a[i]),
      .sec_o        (sec_a[i]),
      .occ_o        (occ_v[i]),
      .go_o         (go_v[i])
    );
  end

  // ---------------- result register ----------------
  logic [VW-1:0]           pad_key;
  logic [VW-1:0]           peak_key_q, quant_key_q, peak_sec_q, quant_sec_q;
  logic [OUT_ID_WIDTH-1:0] peak_id_q, quant_id_q;
  logic                    quant_hit;

  assign pad_key   = (mode_q == MODE_MAX) ? PAD_NEG : PAD_POS;
  // chain head holds rank quantile_rank once the shifts are done
  assign quant_hit = occ_v[0] & (KW'(qrank_q) < keep_eff);

  always_ff @(posedge clk_i) begin
    if (peak_cap) begin
      peak_key_q <= occ_v[0] ? key_a[0] : pad_key;
      peak_id_q  <= occ_v[0] ? OUT_ID_WIDTH'(id_a[0]) : PAD_ID;
      peak_sec_q <= occ_v[0] ? sec_a[0] : PAD_NEG;
    end
    if (quant_cap) begin
      quant_key_q <= quant_hit ? key_a[0] : pad_key;
      quant_id_q  <= quant_hit ? OUT_ID_WIDTH'(id_a[0]) : PAD_ID;
      quant_sec_q <= quant_hit ? sec_a[0] : PAD_NEG;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = ODW'({quant_sec_q, quant_id_q, quant_key_q,
                               peak_sec_q, peak_id_q, peak_key_q});

  // ---------------- assertions ----------------
  `TKPQ_ASSERT_NOW(a_occ_prefix, 1'b1, ((occ_v & (occ_v + 1'b1)) == '0), "occupied cells not a prefix")
  `TKPQ_ASSERT_NEXT(a_clear_empty, ctl.clear, (occ_v == '0), "chain not empty after batch end")
  `TKPQ_ASSERT_NOW(a_rise_from_drain, $rose(m_valid_q), ($past(state_q) == ST_DRAIN), "result raised outside drain")
  `TKPQ_ASSERT_NOW(a_no_shift_ins, ctl.shift, (!ctl.ins && !m_valid_q), "shift overlaps insert or pending result")

endmodule

// File: rtl/core/tkpq_cell.sv
// One cell of the insertion chain: holds one record and its occupied bit.
module tkpq_cell #(
  parameter int VW = tkpq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tkpq_pkg::tkpq_ctl_t           ctl_i,
  input  logic                          in_range_i,
  input  logic                          above_pass_i,
  input  logic [VW-1:0]                 new_key_i,
  input  logic [tkpq_pkg::ID_WIDTH-1:0] new_id_i,
  input  logic [VW-1:0]                 new_sec_i,
  input  logic [VW-1:0]                 prev_key_i,
  input  logic [tkpq_pkg::ID_WIDTH-1:0] prev_id_i,
  input  logic [VW-1:0]                 prev_sec_i,
  input  logic                          prev_occ_i,
  input  logic [VW-1:0]                 next_key_i,
  input  logic [tkpq_pkg::ID_WIDTH-1:0] next_id_i,
  input  logic [VW-1:0]                 next_sec_i,
  input  logic                          next_occ_i,
  output logic [VW-1:0]                 key_o,
  output logic [tkpq_pkg::ID_WIDTH-1:0] id_o,
  output logic [VW-1:0]                 sec_o,
  output logic                          occ_o,
  output logic                          go_o
);
  import tkpq_pkg::*;

  logic [VW-1:0]       key_q, key_d;
  logic [ID_WIDTH-1:0] id_q, id_d;
  logic [VW-1:0]       sec_q, sec_d;
  logic                occ_q, occ_d;
  logic                better;

  assign better = ctl_i.mode ? ($signed(new_key_i) > $signed(key_q))
                             : ($signed(new_key_i) < $signed(key_q));
  // record stays here: the new one ranks behind it
  assign go_o = occ_q & ~better;

  always_comb begin
    key_d = key_q;
    id_d  = id_q;
    sec_d = sec_q;
    occ_d = occ_q;
    priority if (ctl_i.clear) begin
      occ_d = 1'b0;
    end else if (ctl_i.shift) begin
      key_d = next_key_i;
      id_d  = next_id_i;
      sec_d = next_sec_i;
      occ_d = next_occ_i;
    end else if (ctl_i.ins) begin
      priority if (!in_range_i) begin
        occ_d = 1'b0;
      end else if (!above_pass_i) begin
        key_d = prev_key_i;
        id_d  = prev_id_i;
        sec_d = prev_sec_i;
        occ_d = prev_occ_i;
      end else if (!go_o) begin
        key_d = new_key_i;
        id_d  = new_id_i;
        sec_d = new_sec_i;
        occ_d = 1'b1;
      end else begin
        // record ranks ahead of the new one: hold
      end
    end else begin
      // idle: hold
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    id_q  <= id_d;
    sec_q <= sec_d;
  end

  assign key_o = key_q;
  assign id_o  = id_q;
  assign sec_o = sec_q;
  assign occ_o = occ_q;

endmodule

// File: sim/top_k_peak_and_quantile_tb.sv
`timescale 1ns / 1ps
// Testbench for the top-k selector: record batches checked against a predictor of the sorted chain.
module top_k_peak_and_quantile_tb;
  import tkpq_pkg::*;

  localparam int VW            = VALUE_WIDTH_DEF;
  localparam int DEPTH         = CAPACITY_DEF;
  localparam int IN_BITS       = ((2*VW+31+7)/8)*8;
  localparam int OUT_BITS      = ((4*VW+64+7)/8)*8;
  localparam int QBASE         = 2*VW+32;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT   = 3000;
  localparam int RANDOM_ITEMS  = 490;
  localparam int HOLD_CYCLES   = 400;

  localparam logic [63:0]   PAD_SCALED = PAD_MAGNITUDE << FRACTION_BITS_DEF;
  localparam logic [VW-1:0] PAD_HIGH   = PAD_SCALED[VW-1:0];
  localparam logic [VW-1:0] PAD_LOW    = ~PAD_HIGH + 1'b1;
  localparam logic [VW-1:0] KEY_MIN    = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] KEY_MAX    = {1'b0, {(VW-1){1'b1}}};

  typedef struct packed {
    logic [VW-1:0]       key;
    logic [ID_WIDTH-1:0] id;
    logic [VW-1:0]       second;
  } record_t;

  typedef struct packed {
    logic [VW-1:0]           peak_key;
    logic [OUT_ID_WIDTH-1:0] peak_id;
    logic [VW-1:0]           peak_second;
    logic [VW-1:0]           quant_key;
    logic [OUT_ID_WIDTH-1:0] quant_id;
    logic [VW-1:0]           quant_second;
  } report_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_BITS-1:0]    s_axis_tdata;   // sort_key, element_id, companion value
  logic                  s_axis_tlast;   // last_record
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // peak_key, peak_id, peak_second, quant_key, quant_id, quant_second
  logic [OUT_BITS-1:0]   m_axis_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [APB_DWIDTH-1:0] pwdata;
  logic [APB_DWIDTH-1:0] prdata;
  logic                  pready;

  top_k_peak_and_quantile uut (.*);

  // predicted chain and register copies
  record_t                kept [DEPTH];
  bit                     kept_valid [DEPTH];
  logic                   cfg_mode  = MODE_MAX;
  logic [KEEP_WIDTH-1:0]  cfg_keep  = KEEP_WIDTH'(1);
  logic [QRANK_WIDTH-1:0] cfg_qrank = '0;

  report_t pending_reports[$];
  int      error_count  = 0;
  int      quiet_cycles = 0;
  int      rx_hold      = 0;
  bit      tx_gaps_on   = 1'b1;
  bit      rx_stalls_on = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit ranks_ahead(logic [VW-1:0] a, logic [VW-1:0] b);
    if (cfg_mode == MODE_MAX) return $signed(a) > $signed(b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic int kept_limit();
    if (cfg_keep == 0) return 1;
    if (cfg_keep > DEPTH) return DEPTH;
    return int'(cfg_keep);
  endfunction

  function automatic void read_rank(int r, int k, output logic [VW-1:0] key,
                                    output logic [OUT_ID_WIDTH-1:0] id,
                                    output logic [VW-1:0] second);
    if (r < k && kept_valid[r]) begin
      key    = kept[r].key;
      id     = {1'b0, kept[r].id};
      second = kept[r].second;
    end else begin
      key    = (cfg_mode == MODE_MAX) ? PAD_LOW : PAD_HIGH;
      id     = '1;
      second = PAD_LOW;
    end
  endfunction

  // Insert one accepted record; returns 1 with the batch report on a last record.
  function automatic bit insert_record(record_t rec, logic last, output report_t rep);
    int k;
    int p;
    int i;
    k   = kept_limit();
    p   = 0;
    rep = '0;
    // equal keys do not pass, so earlier records keep their rank
    while (p < k && kept_valid[p] && !ranks_ahead(rec.key, kept[p].key)) p++;
    if (p < k) begin
      for (i = k - 1; i > p; i--) begin
        kept[i]       = kept[i-1];
        kept_valid[i] = kept_valid[i-1];
      end
      kept[p]       = rec;
      kept_valid[p] = 1'b1;
    end
    for (i = k; i < DEPTH; i++) kept_valid[i] = 1'b0;
    if (!last) return 1'b0;
    read_rank(0, k, rep.peak_key, rep.peak_id, rep.peak_second);
    read_rank(int'(cfg_qrank), k, rep.quant_key, rep.quant_id, rep.quant_second);
    for (i = 0; i < DEPTH; i++) kept_valid[i] = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [VW-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return VW'(int'($urandom_range(0, 8)) - 4);  // many ties
      1: return ($urandom_range(0, 1) != 0) ? KEY_MAX : KEY_MIN;
      2: return (($urandom_range(0, 1) != 0) ? PAD_HIGH : PAD_LOW) +
                VW'(int'($urandom_range(0, 2)) - 1);
      default: return VW'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [ID_WIDTH-1:0] random_id();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return ID_WIDTH'($urandom);
    endcase
  endfunction

  task automatic send_record(logic [VW-1:0] key, logic [ID_WIDTH-1:0] id,
                             logic [VW-1:0] second, logic last);
    int      gap;
    record_t rec;
    report_t rep;
    gap = tx_gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_BITS'({second, id, key});
    s_axis_tlast  <= last;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    rec.key    = key;
    rec.id     = id;
    rec.second = second;
    if (insert_record(rec, last, rep)) pending_reports.insert(pending_reports.size(), rep);
  endtask

  task automatic send_batch(int count);
    int i;
    for (i = 0; i < count; i++)
      send_record(random_value(), random_id(), random_value(), i == count - 1);
  endtask

  // drop the input, wait for every report, then let a batch end finish its chain walk
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [1:0] index, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (index)
      REG_MODE:  cfg_mode  = value[0];
      REG_KEEP:  cfg_keep  = value[KEEP_WIDTH-1:0];
      REG_QRANK: cfg_qrank = value[QRANK_WIDTH-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(logic mode, int keep, int qrank);
    settle();
    write_register(REG_MODE, 32'(mode));
    write_register(REG_KEEP, 32'(keep));
    write_register(REG_QRANK, 32'(qrank));
  endtask

  task automatic run_reset_defaults();
    // max search, one record kept, rank 0
    send_record(48'sd5, 31'd1, 48'sd50, 1'b0);
    send_record(48'sd9, 31'd2, -48'sd90, 1'b1);
  endtask

  task automatic run_field_extremes();
    configure(MODE_MAX, 8, 3);
    send_record(KEY_MIN, '1, KEY_MAX, 1'b0);
    send_record(KEY_MAX, '0, KEY_MIN, 1'b0);
    send_record('0, 31'd5, '0, 1'b0);
    send_record(48'sd7, 31'd10, 48'sd1, 1'b0);
    send_record(48'sd7, 31'd11, 48'sd2, 1'b0);
    send_record('1, 31'd12, '1, 1'b1);
    // quantile rank beyond the filled cells reads padding
    configure(MODE_MIN, 8, 7);
    send_record(KEY_MAX, 31'd20, 48'sd3, 1'b0);
    send_record(KEY_MIN, 31'd21, 48'sd4, 1'b1);
  endtask

  task automatic run_count_limits();
    configure(MODE_MAX, 0, 0);
    send_record(48'sd1, 31'd30, 48'sd1, 1'b0);
    send_record(48'sd2, 31'd31, 48'sd2, 1'b1);
    configure(MODE_MIN, 127, 63);
    send_record(48'sd4, 31'd32, 48'sd3, 1'b0);
    send_record(-48'sd4, 31'd33, 48'sd4, 1'b1);
    configure(MODE_MAX, 65, 2);
    send_record(48'sd3, 31'd34, 48'sd5, 1'b0);
    send_record(48'sd6, 31'd35, 48'sd6, 1'b0);
    send_record(48'sd5, 31'd36, 48'sd7, 1'b1);
    configure(MODE_MAX, 4, 5);
    send_record(48'sd8, 31'd37, 48'sd8, 1'b0);
    send_record(48'sd9, 31'd38, 48'sd9, 1'b1);
  endtask

  task automatic run_mid_batch_update();
    configure(MODE_MAX, 6, 1);
    send_record(48'sd1, 31'd40, 48'sd1, 1'b0);
    send_record(48'sd4, 31'd41, 48'sd2, 1'b0);
    send_record(48'sd2, 31'd42, 48'sd3, 1'b0);
    // shrink the chain and flip the order while records are still held
    settle();
    write_register(REG_KEEP, 32'd2);
    write_register(REG_MODE, 32'(MODE_MIN));
    send_record(48'sd3, 31'd43, 48'sd4, 1'b0);
    send_record(48'sd10, 31'd44, 48'sd5, 1'b1);
  endtask

  task automatic run_output_stall();
    int n;
    configure(MODE_MAX, 4, 2);
    tx_gaps_on = 1'b0;
    rx_hold    = HOLD_CYCLES;
    for (n = 0; n < 10; n++) send_batch($urandom_range(1, 3));
    settle();
    tx_gaps_on = 1'b1;
  endtask

  task automatic run_random_batches();
    int sent;
    int keep;
    int qrank;
    int len;
    int n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: keep = 1;
        1: keep = DEPTH;
        2: keep = 0;
        3: keep = $urandom_range(DEPTH + 1, 127);
        default: keep = $urandom_range(1, DEPTH);
      endcase
      case ($urandom_range(0, 4))
        0: qrank = 0;
        1: qrank = 63;
        default: qrank = $urandom_range(0, (keep > 1 && keep <= DEPTH) ? keep - 1 : 63);
      endcase
      configure(1'($urandom_range(0, 1)), keep, qrank);
      tx_gaps_on   = $urandom_range(0, 3) != 0;
      rx_stalls_on = $urandom_range(0, 3) != 0;
      for (n = $urandom_range(1, 4); n > 0; n--) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
        send_batch(len);
        sent += len;
      end
    end
  endtask

  // result sink: random stall before each transfer, or a long hold when asked
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_stalls_on ? $urandom_range(0, 10) : 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(posedge clk_i);
      end while (!m_axis_tvalid);
    end
  end

  task automatic check_field(string name, logic [VW-1:0] want, logic [VW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    report_t got;
    report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.peak_key     = m_axis_tdata[VW-1:0];
      got.peak_id      = m_axis_tdata[VW+31:VW];
      got.peak_second  = m_axis_tdata[2*VW+31:VW+32];
      got.quant_key    = m_axis_tdata[QBASE+VW-1:QBASE];
      got.quant_id     = m_axis_tdata[QBASE+VW+31:QBASE+VW];
      got.quant_second = m_axis_tdata[QBASE+2*VW+31:QBASE+VW+32];
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none actual %h", $time, got);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("peak_key", want.peak_key, got.peak_key);
        check_field("peak_id", VW'(want.peak_id), VW'(got.peak_id));
        check_field("peak_second", want.peak_second, got.peak_second);
        check_field("quant_key", want.quant_key, got.quant_key);
        check_field("quant_id", VW'(want.quant_id), VW'(got.quant_id));
        check_field("quant_second", want.quant_second, got.quant_second);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("top_k_peak_and_quantile_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_reset_defaults();
    run_field_extremes();
    run_count_limits();
    run_mid_batch_update();
    run_output_stall();
    run_random_batches();
    settle();
    if (error_count == 0) begin
      $display("top_k_peak_and_quantile_tb: PASS");
    end else begin
      $display("top_k_peak_and_quantile_tb: FAIL");
    end
    $finish;
  end

endmodule
